FILE: rtl/mesh_vertex_normal_average_core_macros.svh
// assertion macros for the vertex normal averaging core
`ifndef MESH_VERTEX_NORMAL_AVERAGE_CORE_MACROS_SVH
`define MESH_VERTEX_NORMAL_AVERAGE_CORE_MACROS_SVH

// property that holds at every clock edge outside reset
`define MVNA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that implies a consequence in the following cycle
`define MVNA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mvna_pkg.sv
// types, constants and state encodings for the vertex normal averaging core
package mvna_pkg;

	localparam int VTX_AW     = 10;
	localparam int VTX_DEPTH  = 1 << VTX_AW;
	localparam int VCNT_W     = VTX_AW + 1;
	localparam int TRI_AW     = 11;
	localparam int TRI_DEPTH  = 1 << TRI_AW;
	localparam int TRI_CNT_W  = TRI_AW + 1;
	localparam int COORD_W    = 16;
	localparam int NORM_W     = 16;
	localparam int ACC_W      = 24;
	localparam int EDGE_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * EDGE_W;
	localparam int VEC_W      = PROD_W + 1;
	localparam int MAG_W      = VEC_W - 1;
	localparam int UNIT_W     = 30;
	localparam int SUM_W      = 2 * UNIT_W + 2;
	localparam int ROOT_W     = UNIT_W + 1;
	localparam int FRAC_W     = 14;
	localparam int QUO_W      = FRAC_W + 1;
	localparam int NUM_W      = UNIT_W + FRAC_W + 1;
	localparam int SQRT_STEPS = SUM_W / 2;
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 64;
	localparam int OP_W       = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0]  norm_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [VEC_W-1:0]   vec_t;
	typedef logic [VTX_AW-1:0]         vidx_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} pos_t;

	typedef struct packed {
		acc_t acc_z;
		acc_t acc_y;
		acc_t acc_x;
		pos_t pos;
	} vtx_t;

	typedef struct packed {
		vidx_t c;
		vidx_t b;
		vidx_t a;
	} tri_t;

	// input word, first field in the lowest bits
	typedef struct packed {
		vidx_t  corner_c;
		vidx_t  corner_b;
		vidx_t  corner_a;
		norm_t  start_nz;
		norm_t  start_ny;
		norm_t  start_nx;
		coord_t pos_z;
		coord_t pos_y;
		coord_t pos_x;
		vidx_t  vertex_index;
	} in_data_t;

	// output word, zero padded to whole bytes
	typedef struct packed {
		logic [5:0] pad;
		norm_t      norm_z;
		norm_t      norm_y;
		norm_t      norm_x;
		vidx_t      out_index;
	} out_data_t;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_RD_RESP,
		C_TRI_CHK,
		C_TRI_LAT,
		C_POS_A,
		C_POS_B,
		C_POS_C,
		C_CROSS,
		C_FACE_NORM,
		C_ACC_RD,
		C_ACC_WR,
		C_VN_CHK,
		C_VN_LAT,
		C_VN_NORM,
		C_DONE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_SHIFT,
		U_SQ,
		U_SQRT,
		U_DIV_INIT,
		U_DIV,
		U_DONE
	} uv_state_t;

	typedef enum logic {
		X_IDLE,
		X_MUL
	} cr_state_t;

endpackage

FILE: rtl/mvna_cross.sv
// cross product of two triangle edges on one shared multiplier
module mvna_cross (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mvna_pkg::pos_t     pa,
	input  mvna_pkg::pos_t     pb,
	input  mvna_pkg::pos_t     pc,
	output logic               done,
	output mvna_pkg::vec_t     cr_x,
	output mvna_pkg::vec_t     cr_y,
	output mvna_pkg::vec_t     cr_z
);

	localparam int STEPS = 6;

	mvna_pkg::cr_state_t st_q, st_next;
	logic [2:0] step_q;
	logic [2:0] prev_step;
	logic signed [mvna_pkg::EDGE_W-1:0] e1_q [3];
	logic signed [mvna_pkg::EDGE_W-1:0] e2_q [3];
	logic signed [mvna_pkg::EDGE_W-1:0] op_a, op_b;
	logic signed [mvna_pkg::PROD_W-1:0] prod, prod_q, hold_q;
	mvna_pkg::vec_t cr_q [3];

	// operand order: y*z - z*y, z*x - x*z, x*y - y*x
	always_comb begin
		unique case (step_q)
			3'd0: begin op_a = e1_q[1]; op_b = e2_q[2]; end
			3'd1: begin op_a = e1_q[2]; op_b = e2_q[1]; end
			3'd2: begin op_a = e1_q[2]; op_b = e2_q[0]; end
			3'd3: begin op_a = e1_q[0]; op_b = e2_q[2]; end
			3'd4: begin op_a = e1_q[0]; op_b = e2_q[1]; end
			3'd5: begin op_a = e1_q[1]; op_b = e2_q[0]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign prod      = mvna_pkg::PROD_W'(op_a) * mvna_pkg::PROD_W'(op_b);
	assign prev_step = step_q - 3'd1;

	// next state, the last difference lands in the cycle after the final product
	always_comb begin
		st_next = st_q;
		unique case (st_q)
			mvna_pkg::X_IDLE: if (start) st_next = mvna_pkg::X_MUL;
			mvna_pkg::X_MUL:  if (step_q == 3'(STEPS + 1)) st_next = mvna_pkg::X_IDLE;
			default:          st_next = mvna_pkg::X_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (st_q == mvna_pkg::X_MUL) && (step_q == 3'(STEPS + 1));
		cr_x = cr_q[0];
		cr_y = cr_q[1];
		cr_z = cr_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= mvna_pkg::X_IDLE;
			step_q <= '0;
		end else begin
			st_q <= st_next;
			if (st_q == mvna_pkg::X_IDLE) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// edge capture, product register and pairwise subtract
	always_ff @(posedge clk) begin
		if (st_q == mvna_pkg::X_IDLE && start) begin
			e1_q[0] <= mvna_pkg::EDGE_W'(pb.x) - mvna_pkg::EDGE_W'(pa.x);
			e1_q[1] <= mvna_pkg::EDGE_W'(pb.y) - mvna_pkg::EDGE_W'(pa.y);
			e1_q[2] <= mvna_pkg::EDGE_W'(pb.z) - mvna_pkg::EDGE_W'(pa.z);
			e2_q[0] <= mvna_pkg::EDGE_W'(pc.x) - mvna_pkg::EDGE_W'(pa.x);
			e2_q[1] <= mvna_pkg::EDGE_W'(pc.y) - mvna_pkg::EDGE_W'(pa.y);
			e2_q[2] <= mvna_pkg::EDGE_W'(pc.z) - mvna_pkg::EDGE_W'(pa.z);
		end
		if (st_q == mvna_pkg::X_MUL) begin
			if (step_q < 3'(STEPS)) prod_q <= prod;
			if (step_q != 3'd0) begin
				if (!prev_step[0]) begin
					hold_q <= prod_q;
				end else begin
					cr_q[prev_step[2:1]] <= mvna_pkg::VEC_W'(hold_q) - mvna_pkg::VEC_W'(prod_q);
				end
			end
		end
	end

endmodule

FILE: rtl/mvna_unit_vec.sv
// iterative vector normalizer: range shift, squares, square root, divide
module mvna_unit_vec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mvna_pkg::vec_t     vin_x,
	input  mvna_pkg::vec_t     vin_y,
	input  mvna_pkg::vec_t     vin_z,
	output logic               done,
	output mvna_pkg::norm_t    q_x,
	output mvna_pkg::norm_t    q_y,
	output mvna_pkg::norm_t    q_z
);

	localparam int UNIT_W = mvna_pkg::UNIT_W;
	localparam int MAG_W  = mvna_pkg::MAG_W;
	localparam int SUM_W  = mvna_pkg::SUM_W;
	localparam int NUM_W  = mvna_pkg::NUM_W;
	localparam int QUO_W  = mvna_pkg::QUO_W;

	mvna_pkg::uv_state_t st_q, st_next;
	mvna_pkg::vec_t vin [3];
	logic [MAG_W-1:0] mag_q [3];
	logic [MAG_W-1:0] mag_or;
	logic [2:0] neg_q;
	logic [1:0] k_q;
	logic [UNIT_W-1:0] m_sel;
	logic [2*UNIT_W-1:0] sq;
	logic [SUM_W-1:0] sum_q, sum_next;
	logic [SUM_W-1:0] n_q;
	logic [SUM_W:0] r_q, bitv, trial, r_next;
	logic [4:0] j_q;
	logic [mvna_pkg::ROOT_W-1:0] len_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W:0] dv;
	logic ge, root_ge, all_zero;
	logic [3:0] i_q;
	logic [QUO_W-1:0] quo_q, quo_next;
	mvna_pkg::norm_t qv;
	mvna_pkg::norm_t q_q [3];

	assign vin[0] = vin_x;
	assign vin[1] = vin_y;
	assign vin[2] = vin_z;
	assign all_zero = (vin_x == '0) && (vin_y == '0) && (vin_z == '0);
	assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];

	// sum of squares, one component a cycle
	assign m_sel    = mag_q[k_q][UNIT_W-1:0];
	assign sq       = m_sel * m_sel;
	assign sum_next = sum_q + SUM_W'(sq);

	// one square-root digit a cycle
	assign bitv    = (SUM_W+1)'(1) << {j_q, 1'b0};
	assign trial   = r_q + bitv;
	assign root_ge = {1'b0, n_q} >= trial;
	assign r_next  = root_ge ? ((r_q >> 1) + bitv) : (r_q >> 1);

	// one quotient bit a cycle
	assign dv       = (NUM_W+1)'(len_q) << i_q;
	assign ge       = {1'b0, rem_q} >= dv;
	assign quo_next = {quo_q[QUO_W-2:0], ge};
	assign qv       = mvna_pkg::NORM_W'(quo_next);

	// next state
	always_comb begin
		st_next = st_q;
		unique case (st_q)
			mvna_pkg::U_IDLE: begin
				if (start) st_next = all_zero ? mvna_pkg::U_DONE : mvna_pkg::U_SHIFT;
			end
			mvna_pkg::U_SHIFT: begin
				if ((mag_or[MAG_W-1:UNIT_W] == '0) && mag_or[UNIT_W-1]) st_next = mvna_pkg::U_SQ;
			end
			mvna_pkg::U_SQ:      if (k_q == 2'd2) st_next = mvna_pkg::U_SQRT;
			mvna_pkg::U_SQRT:    if (j_q == '0) st_next = mvna_pkg::U_DIV_INIT;
			mvna_pkg::U_DIV_INIT: st_next = mvna_pkg::U_DIV;
			mvna_pkg::U_DIV: begin
				if (i_q == '0) st_next = (k_q == 2'd2) ? mvna_pkg::U_DONE : mvna_pkg::U_DIV_INIT;
			end
			mvna_pkg::U_DONE:    st_next = mvna_pkg::U_IDLE;
			default:             st_next = mvna_pkg::U_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (st_q == mvna_pkg::U_DONE);
		q_x  = q_q[0];
		q_y  = q_q[1];
		q_z  = q_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mvna_pkg::U_IDLE;
		end else begin
			st_q <= st_next;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			mvna_pkg::U_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= MAG_W'(vin[i][mvna_pkg::VEC_W-1] ? -vin[i] : vin[i]);
						neg_q[i] <= vin[i][mvna_pkg::VEC_W-1];
						q_q[i]   <= '0;
					end
				end
			end
			mvna_pkg::U_SHIFT: begin
				if (mag_or[MAG_W-1:UNIT_W] != '0) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else if (!mag_or[UNIT_W-1]) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
				end else begin
					k_q   <= '0;
					sum_q <= '0;
				end
			end
			mvna_pkg::U_SQ: begin
				sum_q <= sum_next;
				k_q   <= k_q + 2'd1;
				if (k_q == 2'd2) begin
					n_q <= sum_next;
					r_q <= '0;
					j_q <= 5'(mvna_pkg::SQRT_STEPS - 1);
				end
			end
			mvna_pkg::U_SQRT: begin
				if (root_ge) n_q <= n_q - trial[SUM_W-1:0];
				r_q <= r_next;
				j_q <= j_q - 5'd1;
				if (j_q == '0) begin
					len_q <= r_next[mvna_pkg::ROOT_W-1:0];
					k_q   <= '0;
				end
			end
			mvna_pkg::U_DIV_INIT: begin
				rem_q <= NUM_W'({mag_q[k_q][UNIT_W-1:0], mvna_pkg::FRAC_W'(0)})
					+ NUM_W'(len_q >> 1);
				i_q   <= 4'(mvna_pkg::FRAC_W);
				quo_q <= '0;
			end
			mvna_pkg::U_DIV: begin
				if (ge) rem_q <= rem_q - dv[NUM_W-1:0];
				quo_q <= quo_next;
				i_q   <= i_q - 4'd1;
				if (i_q == '0) begin
					q_q[k_q] <= neg_q[k_q] ? -qv : qv;
					k_q      <= k_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/mesh_vertex_normal_average_core.sv
// top level: vertex and triangle memories with the compute sequencer
// write vertex and append triangle: one word a cycle, no result
// read: result registered from the read response state once the output is free; no new word is taken until then
// compute: a face normal per stored triangle, then a vertex normal per vertex below vertex_count (capped at depth),
//   both through the shared normalizer (bit-serial range shift, square root and divide)
// reset clears control, triangle count and vertex_count; memory contents undefined
`include "mesh_vertex_normal_average_core_macros.svh"

module mesh_vertex_normal_average_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mvna_pkg::VCNT_W-1:0]          cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// vertex_index, pos_x, pos_y, pos_z, start_nx, start_ny, start_nz,
	// corner_a, corner_b, corner_c
	input  logic [mvna_pkg::IN_DATA_W-1:0]       s_tdata,
	// operation
	input  logic [mvna_pkg::OP_W-1:0]            s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_index, norm_x, norm_y, norm_z, zero pad
	output logic [mvna_pkg::OUT_DATA_W-1:0]      m_tdata,
	// compute_done
	output logic [0:0]                           m_tuser
);

	localparam int VTX_AW = mvna_pkg::VTX_AW;
	localparam int ACC_W  = mvna_pkg::ACC_W;

	// saturating accumulator add
	function automatic mvna_pkg::acc_t sat_add(mvna_pkg::acc_t a, mvna_pkg::norm_t b);
		logic signed [ACC_W:0] s;
		s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
		if (s[ACC_W] != s[ACC_W-1]) begin
			sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat_add = s[ACC_W-1:0];
		end
	endfunction

	// accumulator clipped to the normal width
	function automatic mvna_pkg::norm_t sat_norm(mvna_pkg::acc_t a);
		if (a[ACC_W-1:mvna_pkg::NORM_W-1] == '0 || a[ACC_W-1:mvna_pkg::NORM_W-1] == '1) begin
			sat_norm = a[mvna_pkg::NORM_W-1:0];
		end else begin
			sat_norm = a[ACC_W-1] ? {1'b1, {(mvna_pkg::NORM_W-1){1'b0}}}
				: {1'b0, {(mvna_pkg::NORM_W-1){1'b1}}};
		end
	endfunction

	mvna_pkg::ctrl_state_t st_q, st_next;
	mvna_pkg::in_data_t in_d;
	mvna_pkg::op_t op;
	logic s_acc, out_free, load_out, tri_full;
	logic [mvna_pkg::VCNT_W-1:0] vcnt_q, vlim;
	logic [mvna_pkg::TRI_CNT_W-1:0] tri_cnt_q, tidx_q;
	logic [mvna_pkg::VCNT_W-1:0] vidx_q;
	logic [1:0] k_q;
	mvna_pkg::vidx_t rd_idx_q, vaddr, vwaddr, corner;
	mvna_pkg::tri_t tri_q, trd_q;
	mvna_pkg::pos_t pa_q, pb_q;
	mvna_pkg::vtx_t vw_q, vrd_q, vwdata;
	logic vwe, twe;
	mvna_pkg::vtx_t vmem [mvna_pkg::VTX_DEPTH];
	mvna_pkg::tri_t tmem [mvna_pkg::TRI_DEPTH];
	logic cross_start, cross_done, uv_start, uv_done;
	mvna_pkg::vec_t cr_x, cr_y, cr_z, uv_x, uv_y, uv_z;
	mvna_pkg::norm_t n_x, n_y, n_z;
	logic m_tvalid_q;
	mvna_pkg::out_data_t m_data_q, out_next;
	logic m_user_q, user_next;

	assign in_d     = s_tdata;
	assign op       = mvna_pkg::op_t'(s_tuser);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign tri_full = (tri_cnt_q == mvna_pkg::TRI_CNT_W'(mvna_pkg::TRI_DEPTH));
	assign vlim     = (vcnt_q > mvna_pkg::VCNT_W'(mvna_pkg::VTX_DEPTH))
		? mvna_pkg::VCNT_W'(mvna_pkg::VTX_DEPTH) : vcnt_q;

	// corner being accumulated
	always_comb begin
		unique case (k_q)
			2'd0:    corner = tri_q.a;
			2'd1:    corner = tri_q.b;
			default: corner = tri_q.c;
		endcase
	end

	// cross product of the current triangle
	mvna_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cross_start),
		.pa     (pa_q),
		.pb     (pb_q),
		.pc     (vrd_q.pos),
		.done   (cross_done),
		.cr_x   (cr_x),
		.cr_y   (cr_y),
		.cr_z   (cr_z)
	);

	// shared normalizer for face and vertex normals
	mvna_unit_vec u_unit_vec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (uv_start),
		.vin_x  (uv_x),
		.vin_y  (uv_y),
		.vin_z  (uv_z),
		.done   (uv_done),
		.q_x    (n_x),
		.q_y    (n_y),
		.q_z    (n_z)
	);

	// next state
	always_comb begin
		st_next = st_q;
		unique case (st_q)
			mvna_pkg::C_IDLE: begin
				if (s_acc) begin
					unique case (op)
						mvna_pkg::OP_READ:    st_next = mvna_pkg::C_RD_RESP;
						mvna_pkg::OP_COMPUTE: st_next = mvna_pkg::C_TRI_CHK;
						default:              st_next = mvna_pkg::C_IDLE;
					endcase
				end
			end
			mvna_pkg::C_RD_RESP:   if (out_free) st_next = mvna_pkg::C_IDLE;
			mvna_pkg::C_TRI_CHK: begin
				st_next = (tidx_q == tri_cnt_q) ? mvna_pkg::C_VN_CHK : mvna_pkg::C_TRI_LAT;
			end
			mvna_pkg::C_TRI_LAT:   st_next = mvna_pkg::C_POS_A;
			mvna_pkg::C_POS_A:     st_next = mvna_pkg::C_POS_B;
			mvna_pkg::C_POS_B:     st_next = mvna_pkg::C_POS_C;
			mvna_pkg::C_POS_C:     st_next = mvna_pkg::C_CROSS;
			mvna_pkg::C_CROSS:     if (cross_done) st_next = mvna_pkg::C_FACE_NORM;
			mvna_pkg::C_FACE_NORM: if (uv_done) st_next = mvna_pkg::C_ACC_RD;
			mvna_pkg::C_ACC_RD:    st_next = mvna_pkg::C_ACC_WR;
			mvna_pkg::C_ACC_WR: begin
				st_next = (k_q == 2'd2) ? mvna_pkg::C_TRI_CHK : mvna_pkg::C_ACC_RD;
			end
			mvna_pkg::C_VN_CHK: begin
				st_next = (vidx_q == vlim) ? mvna_pkg::C_DONE : mvna_pkg::C_VN_LAT;
			end
			mvna_pkg::C_VN_LAT:    st_next = mvna_pkg::C_VN_NORM;
			mvna_pkg::C_VN_NORM:   if (uv_done) st_next = mvna_pkg::C_VN_CHK;
			mvna_pkg::C_DONE:      if (out_free) st_next = mvna_pkg::C_IDLE;
			default:               st_next = mvna_pkg::C_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		s_tready    = (st_q == mvna_pkg::C_IDLE);
		vaddr       = rd_idx_q;
		vwe         = 1'b0;
		vwaddr      = corner;
		vwdata      = vrd_q;
		twe         = 1'b0;
		cross_start = 1'b0;
		uv_start    = 1'b0;
		uv_x        = cr_x;
		uv_y        = cr_y;
		uv_z        = cr_z;
		load_out    = 1'b0;
		out_next    = '0;
		user_next   = 1'b0;
		unique case (st_q)
			mvna_pkg::C_IDLE: begin
				vaddr             = in_d.vertex_index;
				vwe               = s_acc && (op == mvna_pkg::OP_WRITE);
				vwaddr            = in_d.vertex_index;
				vwdata.pos.x      = in_d.pos_x;
				vwdata.pos.y      = in_d.pos_y;
				vwdata.pos.z      = in_d.pos_z;
				vwdata.acc_x      = ACC_W'(in_d.start_nx);
				vwdata.acc_y      = ACC_W'(in_d.start_ny);
				vwdata.acc_z      = ACC_W'(in_d.start_nz);
				twe               = s_acc && (op == mvna_pkg::OP_APPEND) && !tri_full;
			end
			mvna_pkg::C_RD_RESP: begin
				vaddr              = rd_idx_q;
				load_out           = out_free;
				out_next.out_index = rd_idx_q;
				out_next.norm_x    = sat_norm(vrd_q.acc_x);
				out_next.norm_y    = sat_norm(vrd_q.acc_y);
				out_next.norm_z    = sat_norm(vrd_q.acc_z);
			end
			mvna_pkg::C_TRI_LAT: vaddr = trd_q.a;
			mvna_pkg::C_POS_A:   vaddr = tri_q.b;
			mvna_pkg::C_POS_B:   vaddr = tri_q.c;
			mvna_pkg::C_POS_C:   cross_start = 1'b1;
			mvna_pkg::C_CROSS:   uv_start = cross_done;
			mvna_pkg::C_ACC_RD:  vaddr = corner;
			mvna_pkg::C_ACC_WR: begin
				vwe          = 1'b1;
				vwaddr       = corner;
				vwdata.acc_x = sat_add(vrd_q.acc_x, n_x);
				vwdata.acc_y = sat_add(vrd_q.acc_y, n_y);
				vwdata.acc_z = sat_add(vrd_q.acc_z, n_z);
			end
			mvna_pkg::C_VN_CHK:  vaddr = vidx_q[VTX_AW-1:0];
			mvna_pkg::C_VN_LAT: begin
				uv_start = 1'b1;
				uv_x     = mvna_pkg::VEC_W'(vrd_q.acc_x);
				uv_y     = mvna_pkg::VEC_W'(vrd_q.acc_y);
				uv_z     = mvna_pkg::VEC_W'(vrd_q.acc_z);
			end
			mvna_pkg::C_VN_NORM: begin
				vwe          = uv_done;
				vwaddr       = vidx_q[VTX_AW-1:0];
				vwdata       = vw_q;
				vwdata.acc_x = -ACC_W'(n_x);
				vwdata.acc_y = -ACC_W'(n_y);
				vwdata.acc_z = -ACC_W'(n_z);
			end
			mvna_pkg::C_DONE: begin
				load_out  = out_free;
				user_next = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= mvna_pkg::C_IDLE;
			vcnt_q     <= '0;
			tri_cnt_q  <= '0;
			tidx_q     <= '0;
			vidx_q     <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_next;
			if (cfg_we) vcnt_q <= cfg_wdata;
			if (twe) tri_cnt_q <= tri_cnt_q + 1'b1;
			if (st_q == mvna_pkg::C_IDLE && s_acc) begin
				tidx_q <= '0;
				vidx_q <= '0;
			end
			if (st_q == mvna_pkg::C_FACE_NORM) k_q <= '0;
			if (st_q == mvna_pkg::C_ACC_WR) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd2) tidx_q <= tidx_q + 1'b1;
			end
			if (st_q == mvna_pkg::C_VN_NORM && uv_done) vidx_q <= vidx_q + 1'b1;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (st_q == mvna_pkg::C_IDLE && s_acc) rd_idx_q <= in_d.vertex_index;
		if (st_q == mvna_pkg::C_TRI_LAT) tri_q <= trd_q;
		if (st_q == mvna_pkg::C_POS_A) pa_q <= vrd_q.pos;
		if (st_q == mvna_pkg::C_POS_B) pb_q <= vrd_q.pos;
		if (st_q == mvna_pkg::C_VN_LAT) vw_q <= vrd_q;
		if (load_out) begin
			m_data_q <= out_next;
			m_user_q <= user_next;
		end
	end

	// vertex memory: position and accumulators
	always_ff @(posedge clk) begin
		if (vwe) vmem[vwaddr] <= vwdata;
		vrd_q <= vmem[vaddr];
	end

	// triangle memory
	always_ff @(posedge clk) begin
		if (twe) tmem[tri_cnt_q[mvna_pkg::TRI_AW-1:0]] <= {in_d.corner_c, in_d.corner_b, in_d.corner_a};
		trd_q <= tmem[tidx_q[mvna_pkg::TRI_AW-1:0]];
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;

	// checks
	`MVNA_ASSERT(a_tri_cnt_bound, tri_cnt_q <= mvna_pkg::TRI_CNT_W'(mvna_pkg::TRI_DEPTH), "triangle count past depth")
	`MVNA_ASSERT_NEXT(a_read_result, st_q == mvna_pkg::C_RD_RESP && out_free, m_tvalid && !m_tuser[0], "read result missing")
	`MVNA_ASSERT_NEXT(a_done_result, st_q == mvna_pkg::C_DONE && out_free, m_tvalid && m_tuser[0] && m_tdata == '0, "compute result wrong")
	`MVNA_ASSERT(a_vn_in_range, st_q != mvna_pkg::C_VN_LAT || vidx_q < vlim, "vertex pass beyond limit")

endmodule
